[rtl/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg
// Shared constants and types for the prime sieve bitmap block.
// ----------------------------------------------------------------------------
package psb_pkg;

   localparam int unsigned MAP_BITS  = 4096;
   localparam int unsigned FLAG_W    = 64;                    // flags per stored word
   localparam int unsigned MAP_WORDS = MAP_BITS / FLAG_W;
   localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);     // word address width
   localparam int unsigned BIT_W     = $clog2(FLAG_W);        // bit select width
   localparam int unsigned LIMIT_W   = 12;                    // upper_limit field width
   localparam int unsigned POS_W     = 13;                    // mark pointer width
   localparam int unsigned BASE_W    = 7;                     // bases never pass 64

   // one clear request into the read-modify-write pipe
   typedef struct packed {
      logic               vld;
      logic [WORD_AW-1:0] word;
      logic [BIT_W-1:0]   bit_sel;
   } mark_req_type;

   // one write into the flag memory
   typedef struct packed {
      logic               en;
      logic [WORD_AW-1:0] addr;
      logic [FLAG_W-1:0]  data;
   } ram_wr_type;

endpackage

[rtl/prime_sieve_bitmap.sv]
// ----------------------------------------------------------------------------
// prime_sieve_bitmap
// Sieve of Eratosthenes over a 4096-flag map held in a 64 x 64-bit RAM.
//
// Request channel (req_valid/req_ready): one item carries req_upper_limit.
// req_ready is high only while the block is idle; one item runs at a time.
// Response channel (rsp_valid/rsp_ready): every item produces 64 words in
// order, word_index 0..63, rsp_last_word set on word 63. Bit j of
// rsp_prime_flags is set when 64*word_index+j is prime and <= the limit.
//
// Each item presets all 64 map words, then clears one flag per composite
// mark (base*base, base*base+base and so on up to the limit) for each base
// in turn, then reads the words out in order. The mark count through the one
// RAM write port sets the run time.
// A stalled receiver holds the output register and the sequencer waits.
// The last word may still wait in the output register while the next item
// is accepted.
// Reset (synchronous, active high) returns to idle with no response pending;
// the flag RAM needs no clearing since every item presets it.
// ----------------------------------------------------------------------------
module prime_sieve_bitmap (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [psb_pkg::LIMIT_W-1:0]        req_upper_limit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psb_pkg::WORD_AW-1:0]        rsp_word_index,
   output logic [psb_pkg::FLAG_W-1:0]         rsp_prime_flags,
   output logic                               rsp_last_word
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INIT    = 6'b000010,
      ST_MARK    = 6'b000100,
      ST_DRAIN   = 6'b001000,
      ST_EMIT_RD = 6'b010000,
      ST_EMIT_LD = 6'b100000
   } state_type;

   localparam logic [psb_pkg::WORD_AW-1:0] LAST_WORD = psb_pkg::WORD_AW'(psb_pkg::MAP_WORDS - 1);
   localparam logic [psb_pkg::POS_W-1:0]   MAP_TOP   = psb_pkg::POS_W'(psb_pkg::MAP_BITS - 1);

   state_type                        state_ff, state_in;
   logic [psb_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic [psb_pkg::WORD_AW-1:0]      k_ff, k_in;
   logic [psb_pkg::BASE_W-1:0]       base_ff, base_in;
   logic [psb_pkg::POS_W-1:0]        sq_ff, sq_in;
   logic [psb_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [psb_pkg::WORD_AW-1:0]      rsp_index_ff;
   logic [psb_pkg::FLAG_W-1:0]       rsp_flags_ff;
   logic                             rsp_last_ff;

   psb_pkg::mark_req_type            mark_req;
   psb_pkg::ram_wr_type              mark_wr;
   logic [psb_pkg::FLAG_W-1:0]       rd_data;

   logic                             init_we;
   logic [psb_pkg::FLAG_W-1:0]       init_mask;
   logic [psb_pkg::WORD_AW-1:0]      lim_word;
   logic [psb_pkg::BIT_W-1:0]        lim_bit;
   logic [psb_pkg::POS_W-1:0]        limit_ext;
   logic [psb_pkg::POS_W-1:0]        sq_next;
   logic                             emit_re;
   logic                             rsp_load;
   logic                             ram_we;
   logic [psb_pkg::WORD_AW-1:0]      ram_waddr;
   logic [psb_pkg::FLAG_W-1:0]       ram_wdata;
   logic                             ram_re;
   logic [psb_pkg::WORD_AW-1:0]      ram_raddr;
   logic [psb_pkg::POS_W-1:0]        req_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign limit_ext = psb_pkg::POS_W'(limit_ff);
   assign lim_word  = limit_ff[psb_pkg::LIMIT_W-1:psb_pkg::BIT_W];
   assign lim_bit   = limit_ff[psb_pkg::BIT_W-1:0];
   assign req_ext   = psb_pkg::POS_W'(req_upper_limit);
   // (b+1)^2 = b^2 + 2b + 1
   assign sq_next   = sq_ff + psb_pkg::POS_W'({base_ff, 1'b1});

   // preset word k: flags 2..limit set, everything else clear
   always_comb begin
      if (k_ff < lim_word) begin
         init_mask = '1;
      end else if (k_ff == lim_word) begin
         init_mask = {psb_pkg::FLAG_W{1'b1}} >> (psb_pkg::BIT_W'(psb_pkg::FLAG_W - 1) - lim_bit);
      end else begin
         init_mask = '0;
      end
      if (k_ff == '0) begin
         init_mask[1:0] = 2'b00;
      end
   end

   assign rsp_load = (state_ff == ST_EMIT_LD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in          = state_ff;
      limit_in          = limit_ff;
      k_in              = k_ff;
      base_in           = base_ff;
      sq_in             = sq_ff;
      pos_in            = pos_ff;
      init_we           = 1'b0;
      emit_re           = 1'b0;
      mark_req.vld      = 1'b0;
      mark_req.word     = pos_ff[psb_pkg::LIMIT_W-1:psb_pkg::BIT_W];
      mark_req.bit_sel  = pos_ff[psb_pkg::BIT_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // saturate to the map size
               if (req_ext > MAP_TOP) begin
                  limit_in = psb_pkg::LIMIT_W'(MAP_TOP);
               end else begin
                  limit_in = req_upper_limit;
               end
               k_in     = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            init_we = 1'b1;
            k_in    = k_ff + 1'b1;
            if (k_ff == LAST_WORD) begin
               base_in  = psb_pkg::BASE_W'(2);
               sq_in    = psb_pkg::POS_W'(4);
               pos_in   = psb_pkg::POS_W'(4);
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (pos_ff <= limit_ext) begin
               mark_req.vld = 1'b1;
               pos_in       = pos_ff + psb_pkg::POS_W'(base_ff);
            end else if (sq_next > limit_ext) begin
               state_in = ST_DRAIN;
            end else begin
               base_in = base_ff + 1'b1;
               sq_in   = sq_next;
               pos_in  = sq_next;
            end
         end
         ST_DRAIN: begin
            k_in     = '0;
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            emit_re  = 1'b1;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (rsp_load) begin
               k_in = k_ff + 1'b1;
               if (k_ff == LAST_WORD) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // memory port steering: preset and marking never overlap in time
   assign ram_we    = init_we | mark_wr.en;
   assign ram_waddr = init_we ? k_ff : mark_wr.addr;
   assign ram_wdata = init_we ? init_mask : mark_wr.data;
   assign ram_re    = mark_req.vld | emit_re;
   assign ram_raddr = mark_req.vld ? mark_req.word : k_ff;

   psb_ram #(
      .WIDTH (psb_pkg::FLAG_W),
      .DEPTH (psb_pkg::MAP_WORDS)
   ) u_flag_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_data)
   );

   psb_mark u_mark (
      .clock   (clock),
      .reset   (reset),
      .issue   (mark_req),
      .rd_data (rd_data),
      .wr      (mark_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff <= limit_in;
      k_ff     <= k_in;
      base_ff  <= base_in;
      sq_ff    <= sq_in;
      pos_ff   <= pos_in;
      if (rsp_load) begin
         rsp_index_ff <= k_ff;
         rsp_flags_ff <= rd_data;
         rsp_last_ff  <= (k_ff == LAST_WORD);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_index  = rsp_index_ff;
   assign rsp_prime_flags = rsp_flags_ff;
   assign rsp_last_word   = rsp_last_ff;

   a_start_preset: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_INIT))
      else $error("accepted item did not start the preset");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(init_we && mark_wr.en))
      else $error("preset and mark write collide");

   a_mark_in_phase: assert property (@(posedge clock) disable iff (reset)
      mark_req.vld |-> (state_ff == ST_MARK))
      else $error("clear issued outside the mark phase");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_word) |-> (rsp_word_index == LAST_WORD))
      else $error("last word flag on wrong index");

endmodule

[rtl/psb_ram.sv]
// ----------------------------------------------------------------------------
// psb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module psb_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/psb_mark.sv]
// ----------------------------------------------------------------------------
// psb_mark
// Read-modify-write pipe that clears one flag per request. The read is issued
// by the caller; the data returns in the next cycle and is written back with
// the selected bit cleared. The previous write is forwarded when it hits the
// same word, since the memory returned the old contents for that read.
// ----------------------------------------------------------------------------
module psb_mark (
   input  logic                              clock,
   input  logic                              reset,
   input  psb_pkg::mark_req_type             issue,
   input  logic [psb_pkg::FLAG_W-1:0]        rd_data,
   output psb_pkg::ram_wr_type               wr
);

   psb_pkg::mark_req_type            s1_ff;
   psb_pkg::mark_req_type            s1_in;
   logic                             last_vld_ff;
   logic [psb_pkg::WORD_AW-1:0]      last_addr_ff;
   logic [psb_pkg::FLAG_W-1:0]       last_data_ff;
   logic [psb_pkg::FLAG_W-1:0]       merge_base;
   logic [psb_pkg::FLAG_W-1:0]       clr_mask;

   assign s1_in = issue;

   always_comb begin
      if (last_vld_ff && (last_addr_ff == s1_ff.word)) begin
         merge_base = last_data_ff;
      end else begin
         merge_base = rd_data;
      end
      clr_mask = {{(psb_pkg::FLAG_W-1){1'b0}}, 1'b1} << s1_ff.bit_sel;
   end

   assign wr.en   = s1_ff.vld;
   assign wr.addr = s1_ff.word;
   assign wr.data = merge_base & ~clr_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld   <= 1'b0;
         last_vld_ff <= 1'b0;
      end else begin
         s1_ff.vld   <= s1_in.vld;
         last_vld_ff <= wr.en;
      end
      s1_ff.word    <= s1_in.word;
      s1_ff.bit_sel <= s1_in.bit_sel;
      last_addr_ff  <= wr.addr;
      last_data_ff  <= wr.data;
   end

   a_issue_writes: assert property (@(posedge clock) disable iff (reset)
      issue.vld |=> wr.en)
      else $error("clear request did not produce a write");

   a_bit_cleared: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !wr.data[s1_ff.bit_sel])
      else $error("selected flag not cleared");

   a_fwd_monotone: assert property (@(posedge clock) disable iff (reset)
      (wr.en && $past(wr.en) && (wr.addr == $past(wr.addr)))
         |-> ((wr.data | $past(wr.data)) == $past(wr.data)))
      else $error("back-to-back write to one word restored a cleared flag");

endmodule
